### src/dsbe_pkg.sv
// Shared types, codes and constants of the dense-select block encoder.
package dsbe_pkg;

    localparam logic [7:0]  CASE0_SPAN   = 8'd74;
    localparam logic [31:0] MAX_RUN_DIFF = 32'd512;
    localparam logic [5:0]  CASE0_BITS   = 6'd11;
    localparam logic [2:0]  CASE_ZERO    = 3'd0;
    localparam logic [2:0]  CASE_LAST    = 3'd7;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] KIND_HDR1   = 2'd0;
    localparam logic [1:0] KIND_HDR2   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic push;
        logic fetch_issue;
        logic scan_step;
        logic decide;
        logic fetch_out;
    } t_cmd;

    typedef struct packed {
        logic emitting;
        logic close_now;
        logic run_done;
        logic pipe_busy;
        logic fit;
    } t_status;

    function automatic logic [7:0] span_of(input logic [2:0] c);
        return (c == CASE_ZERO) ? CASE0_SPAN : 8'(8'd128 >> c);
    endfunction

endpackage

### src/dsbe_ctrl.sv
// Controller state machine of the dense-select block encoder.
module dsbe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_op,
    input  dsbe_pkg::t_status i_st,
    output dsbe_pkg::t_cmd    o_cmd,
    output logic             busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == dsbe_pkg::OP_FETCH) begin
                        o_cmd.fetch_issue = 1'b1;
                        n_state = S_FETCH;
                    end else if (!i_st.emitting) begin
                        o_cmd.push = 1'b1;
                        if (i_st.close_now) begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_st.run_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_st.fit ? S_IDLE : S_SCAN;
            end
            S_FETCH: begin
                o_cmd.fetch_out = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### src/dsbe_datapath.sv
// Datapath of the dense-select block encoder: position store, span scan, headers, results.
module dsbe_datapath #(
    parameter int BLOCK_SIZE = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsbe_pkg::t_cmd    i_cmd,
    output dsbe_pkg::t_status o_st,
    input  logic [31:0]       i_position,
    input  logic              i_block_end,
    output logic              o_strobe,
    output logic [1:0]        o_kind,
    output logic [63:0]       o_value,
    output logic [6:0]        o_bit_count,
    output logic              o_final_res
);

    localparam int AW = $clog2(BLOCK_SIZE);
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] BLK      = IW'(BLOCK_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(BLOCK_SIZE - 1);

    logic [31:0]   r_mem [BLOCK_SIZE];
    logic [31:0]   r_rd_a, r_rd_b;

    logic [IW-1:0] r_fill;
    logic [31:0]   r_first, r_last;
    logic          r_emitting;
    logic [2:0]    r_case;
    logic [5:0]    r_w;
    logic [IW-1:0] r_emit_idx;
    logic [55:0]   r_offset;
    logic [63:0]   r_h1, r_h2;

    logic [IW-1:0] r_run;
    logic [2:0]    r_kc;
    logic          r_fit;
    logic [5:0]    r_wacc;
    logic [10:0]   r_s [1:6];

    logic          r_v1, r_v2;
    logic [IW-1:0] r_ia1, r_ib1;
    logic [2:0]    r_k1, r_k2;
    logic [31:0]   r_ra2, r_rb2;

    logic          r_fp_live, r_fp_final, r_fp_samp;
    logic [1:0]    r_fp_kind;
    logic [63:0]   r_fp_val;
    logic [6:0]    r_fp_bits;

    logic [IW-1:0] span_w, run_end, b_idx, a_idx, samp_idx, s_num;
    logic [2:0]    shamt;
    logic [IW:0]   cnt;
    logic [IW+6:0] prod;
    logic [IW:0]   total;
    logic          last_item, close_now, fit_now;
    logic [5:0]    bl2;
    logic [31:0]   rel_fetch;

    function automatic logic [31:0] rel(input logic [IW-1:0] idx, input logic [31:0] data,
                                        input logic [IW-1:0] fill, input logic [31:0] first,
                                        input logic [31:0] last);
        logic [IW-1:0] ext;
        ext = idx - fill + IW'(1);
        if (idx < fill) begin
            return data - first;
        end
        return last + 32'(ext) - first;
    endfunction

    function automatic logic [5:0] bitlen(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 6'(i + 1);
        end
        return n;
    endfunction

    // scan addressing
    assign span_w  = IW'(dsbe_pkg::span_of(r_case));
    assign run_end = r_run + span_w - IW'(1);
    assign b_idx   = (run_end > LAST_IDX) ? LAST_IDX : run_end;
    assign shamt   = 3'd7 - r_case;
    assign s_num   = r_emit_idx - IW'(2);
    assign samp_idx = (r_emit_idx < IW'(2)) ? '0 : IW'(s_num << shamt);
    assign a_idx   = i_cmd.fetch_issue ? samp_idx : r_run;

    // sample count and result totals for the current case
    assign cnt   = (IW+1)'((BLK + span_w - IW'(1)) >> shamt);
    assign prod  = (IW+7)'(cnt) * (IW+7)'(r_wacc);
    assign total = (r_case == dsbe_pkg::CASE_ZERO || r_w == 6'd0)
                   ? (IW+1)'(2) : cnt + (IW+1)'(2);
    assign last_item = ((IW+1)'(r_emit_idx) + (IW+1)'(1)) >= total;

    assign close_now = i_block_end || (r_fill == LAST_IDX);
    assign fit_now   = (r_case == dsbe_pkg::CASE_LAST)
                       || (r_fit && (r_case != dsbe_pkg::CASE_ZERO
                                     || r_wacc <= dsbe_pkg::CASE0_BITS));
    assign bl2       = bitlen(r_ra2);
    assign rel_fetch = rel(r_ia1, r_rd_a, r_fill, r_first, r_last);

    always_comb begin
        o_st.emitting  = r_emitting;
        o_st.close_now = close_now;
        o_st.run_done  = (r_run >= BLK);
        o_st.pipe_busy = r_v1 | r_v2;
        o_st.fit       = fit_now;
    end

    // position store
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_fill[AW-1:0]] <= i_position;
        end
        r_rd_a <= r_mem[a_idx[AW-1:0]];
        r_rd_b <= r_mem[b_idx[AW-1:0]];
    end

    // scan pipeline payload
    always_ff @(posedge i_clk) begin
        r_ia1 <= a_idx;
        r_ib1 <= b_idx;
        r_k1  <= r_kc;
        r_ra2 <= rel(r_ia1, r_rd_a, r_fill, r_first, r_last);
        r_rb2 <= rel(r_ib1, r_rd_b, r_fill, r_first, r_last);
        r_k2  <= r_k1;
        if (r_v2 && r_case == dsbe_pkg::CASE_ZERO && r_k2 >= 3'd1 && r_k2 <= 3'd6) begin
            r_s[r_k2] <= r_ra2[10:0];
        end
        if (i_cmd.push) begin
            r_last <= i_position;
            if (r_fill == '0) begin
                r_first <= i_position;
            end
        end
        if (i_cmd.fetch_issue) begin
            r_fp_live  <= r_emitting;
            r_fp_final <= r_emitting && last_item;
            if (!r_emitting) begin
                r_fp_kind <= dsbe_pkg::KIND_NONE;
                r_fp_samp <= 1'b0;
                r_fp_val  <= '0;
                r_fp_bits <= '0;
            end else if (r_emit_idx == '0) begin
                r_fp_kind <= dsbe_pkg::KIND_HDR1;
                r_fp_samp <= 1'b0;
                r_fp_val  <= r_h1;
                r_fp_bits <= 7'd64;
            end else if (r_emit_idx == IW'(1)) begin
                r_fp_kind <= dsbe_pkg::KIND_HDR2;
                r_fp_samp <= 1'b0;
                r_fp_val  <= r_h2;
                r_fp_bits <= 7'd64;
            end else begin
                r_fp_kind <= dsbe_pkg::KIND_SAMPLE;
                r_fp_samp <= 1'b1;
                r_fp_val  <= '0;
                r_fp_bits <= {1'b0, r_w};
            end
        end
        if (i_cmd.fetch_out) begin
            o_kind      <= r_fp_kind;
            o_value     <= r_fp_samp ? 64'(rel_fetch) : r_fp_val;
            o_bit_count <= r_fp_bits;
            o_final_res <= r_fp_final;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_emitting <= 1'b0;
            r_case     <= '0;
            r_w        <= '0;
            r_emit_idx <= '0;
            r_offset   <= '0;
            r_h1       <= '0;
            r_h2       <= '0;
            r_run      <= '0;
            r_kc       <= '0;
            r_fit      <= 1'b1;
            r_wacc     <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_v1     <= i_cmd.scan_step;
            r_v2     <= r_v1;
            o_strobe <= i_cmd.fetch_out;
            if (i_cmd.push) begin
                r_fill <= r_fill + IW'(1);
                if (close_now) begin
                    r_case <= dsbe_pkg::CASE_ZERO;
                    r_run  <= '0;
                    r_kc   <= '0;
                    r_fit  <= 1'b1;
                    r_wacc <= '0;
                end
            end
            if (i_cmd.scan_step) begin
                r_run <= r_run + span_w;
                if (r_kc != 3'd7) r_kc <= r_kc + 3'd1;
            end
            if (r_v2) begin
                if (r_rb2 - r_ra2 > dsbe_pkg::MAX_RUN_DIFF) r_fit <= 1'b0;
                if (bl2 > r_wacc) r_wacc <= bl2;
            end
            if (i_cmd.decide) begin
                if (fit_now) begin
                    r_emitting <= 1'b1;
                    r_w        <= r_wacc;
                    r_emit_idx <= '0;
                    if (r_case == dsbe_pkg::CASE_ZERO) begin
                        r_h1 <= {r_s[6][10:9], 3'b000, r_case, 24'h0, r_first};
                        r_h2 <= {r_s[6][8:0], r_s[5], r_s[4], r_s[3], r_s[2], r_s[1]};
                    end else begin
                        r_h1     <= {2'b00, 3'b000, r_case, 24'h0, r_first};
                        r_h2     <= {2'b00, r_wacc, r_offset};
                        r_offset <= r_offset + 56'(prod);
                    end
                end else begin
                    r_case <= r_case + 3'd1;
                    r_run  <= '0;
                    r_kc   <= '0;
                    r_fit  <= 1'b1;
                    r_wacc <= '0;
                end
            end
            if (i_cmd.fetch_out && r_fp_live) begin
                if (r_fp_final) begin
                    r_emitting <= 1'b0;
                    r_fill     <= '0;
                    r_emit_idx <= '0;
                end else begin
                    r_emit_idx <= r_emit_idx + IW'(1);
                end
            end
        end
    end

endmodule

### src/dense_select_block_encoder_core.sv
// Top level of the dense-select block encoder: controller, datapath and checks.
//
// Usage: present an item on i_op, i_position and i_block_end with start high; it is
// taken at a rising edge where busy is low. A push (op 0) stores one ascending
// position and produces no result; a push while a block is still being read out
// is dropped. A push with i_block_end set, or the push that fills BLOCK_SIZE
// positions, closes the block and raises busy while the span search runs.
// The search tries span 74 and then 64, 32, ..., 2 (span 1 is taken without a
// check); each try walks the block one run per cycle through a two-port read of
// the position store and lets the scan pipeline drain before deciding on a fit.
// A fetch (op 1) reads the store in the accept cycle and moves to the fetch state,
// which registers the result onto o_kind, o_value, o_bit_count and o_final_res;
// o_strobe is high for exactly one cycle, in the cycle that busy falls. Results
// run header word one, header word two, then the overflow samples; a fetch with
// nothing pending returns kind 3 with zero fields.
// The receiver cannot stall: it must take each result in the cycle it is strobed.
// Reset (synchronous, active low) empties the block, clears the overflow offset
// and headers and returns to loading; the store itself is not cleared.
module dense_select_block_encoder_core #(
    parameter int BLOCK_SIZE = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [31:0] i_position,
    input  logic        i_block_end,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [63:0] o_value,
    output logic [6:0]  o_bit_count,
    output logic        o_final_res
);

    dsbe_pkg::t_cmd    cmd;
    dsbe_pkg::t_status st;

    // sequence pushes, span search passes and fetches
    dsbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_st    (st),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // hold positions, run the span checks, build headers and drive results
    dsbe_datapath #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_position  (i_position),
        .i_block_end (i_block_end),
        .o_strobe    (o_strobe),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_bit_count (o_bit_count),
        .o_final_res (o_final_res)
    );

    // a result only follows a fetch that went through the datapath
    a_strobe_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(cmd.fetch_out))
        else $error("result strobed without a fetch");

    // a store write never lands while a block is being read out
    a_no_push_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !st.emitting)
        else $error("push taken while emitting");

    // the scan never steps past the end of the block
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step |-> !st.run_done)
        else $error("scan step beyond block end");

    // an empty fetch never closes a block
    a_none_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == dsbe_pkg::KIND_NONE) |-> !o_final_res)
        else $error("empty result marked final");

endmodule
